// File: design/igmp_rejoin_timer_report_gen_core_macros.svh
// ------------------------------------------------------------------------
// Assertion macros for the IGMP rejoin timer core
// Clocked on clk and disabled while arst_n is low.
// ------------------------------------------------------------------------
`ifndef IGMP_REJOIN_TIMER_REPORT_GEN_CORE_MACROS_SVH
`define IGMP_REJOIN_TIMER_REPORT_GEN_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define IRTRG_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define IRTRG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define IRTRG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define IRTRG_ASSERT(lbl, cond)
`define IRTRG_ASSERT_IMP(lbl, ante, cons)
`define IRTRG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: design/irtrg_pkg.sv
// ------------------------------------------------------------------------
// irtrg_pkg
// Types and constants of the IGMP rejoin timer and report generator.
// ------------------------------------------------------------------------
package irtrg_pkg;

	localparam int unsigned TIME_W = 48;
	localparam int unsigned SECS_W = 16;
	localparam int unsigned MS_W   = 26;	// 65535 s in ms
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [9:0] MS_PER_S = 10'd1000;

	localparam logic [7:0] V2_TYPE = 8'h16;
	localparam logic [7:0] V3_TYPE = 8'h22;

	localparam logic [31:0] V3_NGREC_WORD = 32'h0000_0001;
	localparam logic [31:0] V3_REC_EXCL   = 32'h0200_0000;
	localparam logic [31:0] V3_REC_INCL   = 32'h0100_0001;

	localparam logic [15:0] TIMEOUT_RST_S = 16'd5;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_DATA  = 2'd1,
		FUNC_ERROR = 2'd2,
		FUNC_START = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_V2     = 2'd1,
		KIND_V3     = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GROUP    = 3'd0,
		CFG_SOURCE   = 3'd1,
		CFG_SSM      = 3'd2,
		CFG_IPV4     = 3'd3,
		CFG_REJOIN_S = 3'd4,
		CFG_TIMEOUT_S = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BURST_STATUS = 2'd0,
		BURST_ASM    = 2'd1,	// v2 report then v3 exclude report
		BURST_SSM    = 2'd2	// v3 include report only
	} burst_mode_t;

	typedef struct packed {
		burst_mode_t mode;
		logic        failed;
	} burst_t;

	// RFC 1071 fold of a short 16-bit word sum, then complement
	function automatic logic [15:0] csum_fold(input logic [18:0] sum);
		logic [16:0] s1;
		logic [15:0] s2;
		s1 = {14'd0, sum[18:16]} + {1'b0, sum[15:0]};
		s2 = s1[15:0] + {15'd0, s1[16]};
		return ~s2;
	endfunction

endpackage

// File: design/irtrg_in_if.sv
// ------------------------------------------------------------------------
// irtrg_in_if
// Event channel: function code and millisecond timestamp.
// ------------------------------------------------------------------------
interface irtrg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [47:0] now_ms;

	modport source (output valid, output func, output now_ms, input ready);
	modport sink   (input valid, input func, input now_ms, output ready);
endinterface

// File: design/irtrg_out_if.sv
// ------------------------------------------------------------------------
// irtrg_out_if
// Result channel: status or membership report words.
// ------------------------------------------------------------------------
interface irtrg_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] word;
	logic        last;
	logic        failed;

	modport source (output valid, output kind, output word, output last, output failed,
		input ready);
	modport sink   (input valid, input kind, input word, input last, input failed,
		output ready);
endinterface

// File: design/igmp_rejoin_timer_report_gen_core.sv
// ------------------------------------------------------------------------
// igmp_rejoin_timer_report_gen_core
// Multicast rejoin timer, liveness watchdog and IGMP report generator.
// ------------------------------------------------------------------------
// Each event item passes an input register, where the timer compares and
// state update are done, into a burst register that drives the result
// channel. Items that give one status result stream at one per cycle while
// the result channel is ready. A tick that triggers a rejoin gives six words
// (any-source: IGMPv2 then IGMPv3 report) or five words (source-specific),
// one per cycle from the burst register while the result channel is ready;
// the next event waits in the input register meanwhile. The checksums are
// formed from the group and source registers as the words go out.
`include "igmp_rejoin_timer_report_gen_core_macros.svh"

module igmp_rejoin_timer_report_gen_core
	import irtrg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_wdata,
	irtrg_in_if.sink             evt,
	irtrg_out_if.source          rpt
);

	// configuration
	logic [31:0]     group_q;
	logic [31:0]     source_q;
	logic            ssm_q;
	logic            ipv4_q;
	logic            rejoin_en_q;
	logic [MS_W-1:0] rejoin_ms_q;
	logic [MS_W-1:0] timeout_ms_q;

	logic [MS_W-1:0] wdata_ms;
	assign wdata_ms = {10'd0, cfg_wdata[SECS_W-1:0]} * {16'd0, MS_PER_S};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q      <= '0;
			source_q     <= '0;
			ssm_q        <= 1'b0;
			ipv4_q       <= 1'b1;
			rejoin_en_q  <= 1'b0;
			rejoin_ms_q  <= '0;
			timeout_ms_q <= MS_W'(TIMEOUT_RST_S * MS_PER_S);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GROUP:     group_q  <= cfg_wdata;
				CFG_SOURCE:    source_q <= cfg_wdata;
				CFG_SSM:       ssm_q    <= cfg_wdata[0];
				CFG_IPV4:      ipv4_q   <= cfg_wdata[0];
				CFG_REJOIN_S: begin
					rejoin_en_q <= (cfg_wdata[SECS_W-1:0] != '0);
					rejoin_ms_q <= wdata_ms;
				end
				CFG_TIMEOUT_S: timeout_ms_q <= wdata_ms;
				default: ;
			endcase
		end
	end

	// input register
	logic              valid_s1;
	func_t             func_s1;
	logic [TIME_W-1:0] now_s1;

	// timer state
	logic [TIME_W-1:0] last_data_q;
	logic [TIME_W-1:0] last_rejoin_q;
	logic              failed_q;

	// burst register
	logic       burst_valid_q;
	burst_t     burst_q;
	logic [2:0] idx_q;

	logic move;
	logic rpt_last;
	logic evt_acc;

	assign move    = valid_s1 && (!burst_valid_q || (rpt.ready && rpt_last));
	assign evt.ready = !valid_s1 || move;
	assign evt_acc = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_acc) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_acc) begin
			func_s1 <= func_t'(evt.func);
			now_s1  <= evt.now_ms;
		end
	end

	// event evaluation
	logic        rejoin_due;
	logic        timeout_due;
	logic        rejoin_hit;
	logic        failed_nxt;
	burst_mode_t mode_nxt;

	assign rejoin_due  = {1'b0, now_s1} >=
		({1'b0, last_rejoin_q} + (TIME_W+1)'(rejoin_ms_q));
	assign timeout_due = {1'b0, now_s1} >=
		({1'b0, last_data_q} + (TIME_W+1)'(timeout_ms_q));
	assign rejoin_hit  = (func_s1 == FUNC_TICK) && !failed_q && rejoin_en_q && ipv4_q
		&& rejoin_due;

	always_comb begin
		case (func_s1)
			FUNC_START: failed_nxt = 1'b0;
			FUNC_ERROR: failed_nxt = 1'b1;
			FUNC_TICK:  failed_nxt = failed_q || timeout_due;
			default:    failed_nxt = failed_q;
		endcase
		if (rejoin_hit) begin
			mode_nxt = ssm_q ? BURST_SSM : BURST_ASM;
		end else begin
			mode_nxt = BURST_STATUS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_data_q   <= '0;
			last_rejoin_q <= '0;
			failed_q      <= 1'b0;
		end else if (move) begin
			failed_q <= failed_nxt;
			if (func_s1 == FUNC_START || func_s1 == FUNC_DATA) begin
				last_data_q <= now_s1;
			end
			if (func_s1 == FUNC_START || rejoin_hit) begin
				last_rejoin_q <= now_s1;
			end
		end
	end

	// burst sequencing
	logic rpt_acc;
	assign rpt_acc = rpt.valid && rpt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_valid_q <= 1'b0;
			idx_q         <= '0;
		end else if (move) begin
			burst_valid_q <= 1'b1;
			idx_q         <= '0;
		end else if (rpt_acc) begin
			if (rpt_last) begin
				burst_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			burst_q.mode   <= mode_nxt;
			burst_q.failed <= failed_nxt;
		end
	end

	// report words; the source-specific sum can exceed 18 bits
	logic [15:0] csum_v2;
	logic [15:0] csum_v3;
	logic [18:0] sum_grp;
	logic [18:0] sum_src;

	assign sum_grp = {3'b000, group_q[31:16]} + {3'b000, group_q[15:0]};
	assign sum_src = {3'b000, source_q[31:16]} + {3'b000, source_q[15:0]};
	assign csum_v2 = csum_fold({3'b000, V2_TYPE, 8'h00} + sum_grp);
	assign csum_v3 = ssm_q
		? csum_fold({3'b000, V3_TYPE, 8'h00} + 19'(V3_NGREC_WORD[15:0])
			+ 19'(V3_REC_INCL[31:16]) + 19'(V3_REC_INCL[15:0]) + sum_grp + sum_src)
		: csum_fold({3'b000, V3_TYPE, 8'h00} + 19'(V3_NGREC_WORD[15:0])
			+ 19'(V3_REC_EXCL[31:16]) + sum_grp);

	kind_t       kind_o;
	logic [31:0] word_o;

	always_comb begin
		kind_o   = KIND_STATUS;
		word_o   = '0;
		rpt_last = 1'b1;
		case (burst_q.mode)
			BURST_ASM: begin
				kind_o   = (idx_q < 3'd2) ? KIND_V2 : KIND_V3;
				rpt_last = (idx_q == 3'd5);
				case (idx_q)
					3'd0:    word_o = {V2_TYPE, 8'h00, csum_v2};
					3'd1:    word_o = group_q;
					3'd2:    word_o = {V3_TYPE, 8'h00, csum_v3};
					3'd3:    word_o = V3_NGREC_WORD;
					3'd4:    word_o = V3_REC_EXCL;
					default: word_o = group_q;
				endcase
			end
			BURST_SSM: begin
				kind_o   = KIND_V3;
				rpt_last = (idx_q == 3'd4);
				case (idx_q)
					3'd0:    word_o = {V3_TYPE, 8'h00, csum_v3};
					3'd1:    word_o = V3_NGREC_WORD;
					3'd2:    word_o = V3_REC_INCL;
					3'd3:    word_o = group_q;
					default: word_o = source_q;
				endcase
			end
			default: ;
		endcase
	end

	assign rpt.valid  = burst_valid_q;
	assign rpt.kind   = kind_o;
	assign rpt.word   = word_o;
	assign rpt.last   = rpt_last;
	assign rpt.failed = burst_q.failed;

	// checks
	`IRTRG_ASSERT_IMP(a_stall_holds_s1, !evt.ready, valid_s1)
	`IRTRG_ASSERT_IMP(a_status_single, rpt.valid && rpt.kind == KIND_STATUS,
		rpt.last && rpt.word == '0)
	`IRTRG_ASSERT_NEXT(a_start_clears, move && func_s1 == FUNC_START, !failed_q)
	`IRTRG_ASSERT_IMP(a_fail_sticky, $fell(failed_q),
		$past(move) && $past(func_s1) == FUNC_START)

endmodule
